[rtl/cleaner_cycle_sequencer_unit_defines.svh]
// assertion macros for the cleaner cycle sequencer
`ifndef CLEANER_CYCLE_SEQUENCER_UNIT_DEFINES_SVH
`define CLEANER_CYCLE_SEQUENCER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define CCS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("ccs assertion failed");
`define CCS_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("ccs assertion failed");
`else
`define CCS_ASSERT(lbl, prop)
`define CCS_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

[rtl/ccs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ccs_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int TICK_W     = 16;
    localparam int SPEED_W    = 7;
    localparam int STATE_W    = 3;

    localparam logic [CFG_IDX_W-1:0] REG_WASH_TICKS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DRY_TICKS     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DRY_MIN_TICKS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_PERCENT = 2'd3;

    localparam logic [STATE_W-1:0] ST_IDLE      = 3'd0;
    localparam logic [STATE_W-1:0] ST_READY     = 3'd1;
    localparam logic [STATE_W-1:0] ST_FILLING   = 3'd2;
    localparam logic [STATE_W-1:0] ST_WASHING   = 3'd3;
    localparam logic [STATE_W-1:0] ST_UNFILLING = 3'd4;
    localparam logic [STATE_W-1:0] ST_DRYING    = 3'd5;
    localparam logic [STATE_W-1:0] ST_EMPTY     = 3'd6;
    localparam logic [STATE_W-1:0] ST_FINISHED  = 3'd7;

    localparam logic [SPEED_W-1:0] SPEED_MAX = 7'd100;

    typedef struct packed {
        logic start_pressed;
        logic disk_present;
        logic tank_full;
        logic reservoir_ok;
        logic tank_drain_sensor;
    } in_t;

    typedef struct packed {
        logic [STATE_W-1:0] mode;
        logic               motor_en;
        logic [SPEED_W-1:0] motor_speed;
        logic               pump_on;
        logic               fan_on;
        logic               valve_open;
        logic               ultrasound_on;
        logic               beep;
        logic [TICK_W-1:0]  wash_left;
        logic [TICK_W-1:0]  dry_left;
    } out_t;

    typedef struct packed {
        logic [TICK_W-1:0]  wash_ticks;
        logic [TICK_W-1:0]  dry_ticks;
        logic [TICK_W-1:0]  dry_min_ticks;
        logic [SPEED_W-1:0] speed_percent;
    } cfg_t;

    typedef struct packed {
        logic [STATE_W-1:0] cycle_state;
        logic [TICK_W-1:0]  wash_count;
        logic [TICK_W-1:0]  dry_count;
        logic               beep_flag;
    } seq_state_t;

endpackage

`default_nettype wire

[rtl/ccs_cfg.sv]
`timescale 1ns / 1ps
`default_nettype none

module ccs_cfg (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [ccs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ccs_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output ccs_pkg::cfg_t                       cfg
);

    ccs_pkg::cfg_t cfg_reg;
    ccs_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                ccs_pkg::REG_WASH_TICKS: begin
                    cfg_next.wash_ticks = cfg_wdata;
                end
                ccs_pkg::REG_DRY_TICKS: begin
                    cfg_next.dry_ticks = cfg_wdata;
                end
                ccs_pkg::REG_DRY_MIN_TICKS: begin
                    cfg_next.dry_min_ticks = cfg_wdata;
                end
                ccs_pkg::REG_SPEED_PERCENT: begin
                    cfg_next.speed_percent = cfg_wdata[ccs_pkg::SPEED_W-1:0];
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

[rtl/ccs_step.sv]
`timescale 1ns / 1ps
`default_nettype none

module ccs_step (
    input  wire ccs_pkg::cfg_t       cfg,
    input  wire ccs_pkg::seq_state_t cur,
    input  wire ccs_pkg::in_t        tick,
    output ccs_pkg::seq_state_t      nxt,
    output ccs_pkg::out_t            result
);

    logic [ccs_pkg::SPEED_W-1:0] spd;

    always_comb begin
        nxt = cur;
        case (cur.cycle_state)
            ccs_pkg::ST_IDLE: begin
                nxt.wash_count = cfg.wash_ticks;
                nxt.dry_count  = cfg.dry_ticks;
                if (!tick.reservoir_ok) begin
                    nxt.cycle_state = ccs_pkg::ST_EMPTY;
                end else if (tick.disk_present) begin
                    nxt.cycle_state = ccs_pkg::ST_READY;
                end
            end
            ccs_pkg::ST_READY: begin
                nxt.wash_count = cfg.wash_ticks;
                nxt.dry_count  = cfg.dry_ticks;
                if (!tick.disk_present) begin
                    nxt.cycle_state = ccs_pkg::ST_IDLE;
                end else if (tick.start_pressed) begin
                    nxt.cycle_state = ccs_pkg::ST_FILLING;
                end
            end
            ccs_pkg::ST_FILLING: begin
                if (tick.tank_full) begin
                    nxt.cycle_state = ccs_pkg::ST_WASHING;
                end
            end
            ccs_pkg::ST_WASHING: begin
                // saturating countdown
                if (cur.wash_count <= ccs_pkg::TICK_W'(1)) begin
                    nxt.wash_count  = '0;
                    nxt.cycle_state = ccs_pkg::ST_UNFILLING;
                end else begin
                    nxt.wash_count = cur.wash_count - ccs_pkg::TICK_W'(1);
                end
            end
            ccs_pkg::ST_UNFILLING: begin
                if (!tick.tank_drain_sensor) begin
                    if (cfg.dry_ticks < cfg.dry_min_ticks) begin
                        nxt.cycle_state = ccs_pkg::ST_IDLE;
                    end else begin
                        nxt.dry_count   = cfg.dry_ticks;
                        nxt.cycle_state = ccs_pkg::ST_DRYING;
                    end
                end
            end
            ccs_pkg::ST_DRYING: begin
                if (cur.dry_count <= ccs_pkg::TICK_W'(1)) begin
                    nxt.dry_count   = '0;
                    nxt.cycle_state = ccs_pkg::ST_FINISHED;
                end else begin
                    nxt.dry_count = cur.dry_count - ccs_pkg::TICK_W'(1);
                end
            end
            ccs_pkg::ST_EMPTY: begin
                if (tick.reservoir_ok) begin
                    nxt.beep_flag   = 1'b0;
                    nxt.cycle_state = ccs_pkg::ST_IDLE;
                end else begin
                    nxt.beep_flag = 1'b1;
                end
            end
            default: begin
                if (!tick.disk_present) begin
                    nxt.cycle_state = ccs_pkg::ST_IDLE;
                end
            end
        endcase
    end

    assign spd = (cfg.speed_percent > ccs_pkg::SPEED_MAX) ? ccs_pkg::SPEED_MAX
                                                          : cfg.speed_percent;

    // drive decode from the new state
    always_comb begin
        result               = '0;
        result.mode          = nxt.cycle_state;
        result.beep          = nxt.beep_flag;
        result.wash_left     = nxt.wash_count;
        result.dry_left      = nxt.dry_count;
        case (nxt.cycle_state)
            ccs_pkg::ST_IDLE, ccs_pkg::ST_READY, ccs_pkg::ST_UNFILLING: begin
                result.valve_open = 1'b1;
            end
            ccs_pkg::ST_FILLING: begin
                result.pump_on = 1'b1;
            end
            ccs_pkg::ST_WASHING: begin
                result.motor_en      = 1'b1;
                result.motor_speed   = spd;
                result.ultrasound_on = 1'b1;
            end
            ccs_pkg::ST_DRYING: begin
                result.motor_en    = 1'b1;
                result.motor_speed = spd;
                result.fan_on      = 1'b1;
            end
            ccs_pkg::ST_EMPTY: begin
                result.motor_en   = 1'b1;
                result.fan_on     = 1'b1;
                result.valve_open = 1'b1;
            end
            default: begin
                result.motor_en = 1'b1;
                result.fan_on   = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/cleaner_cycle_sequencer_unit.sv]
// Cleaner cycle sequencer. Each transfer on s_ is one control tick (start button and four
// sensor levels); each tick yields exactly one transfer on m_ with the new cycle state, the
// drive outputs and both countdowns. Ticks pass an input register, then one step of the
// state machine and output decode, then the result register, so the block takes one tick
// every cycle while m_ready keeps up, and m_ is driven straight from the result register;
// a stalled m_ready holds one result and one queued tick before s_ready drops.
// Configuration is a plain write port (cfg_wr_en, cfg_index, cfg_wdata) and should only be
// written while no tick is in flight.
`timescale 1ns / 1ps
`default_nettype none
`include "cleaner_cycle_sequencer_unit_defines.svh"

module cleaner_cycle_sequencer_unit (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [ccs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ccs_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                           s_valid,
    output      logic                           s_ready,
    input  wire ccs_pkg::in_t                   s_data,
    output      logic                           m_valid,
    input  wire logic                           m_ready,
    output ccs_pkg::out_t                       m_data
);

    ccs_pkg::cfg_t       cfg;
    ccs_pkg::seq_state_t state_reg;
    ccs_pkg::seq_state_t state_next;
    ccs_pkg::in_t        in_data_reg;
    logic                in_valid_reg;
    ccs_pkg::out_t       out_data_reg;
    ccs_pkg::out_t       out_data_next;
    logic                out_valid_reg;
    logic                advance;

    ccs_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    ccs_step u_step (
        .cfg    (cfg),
        .cur    (state_reg),
        .tick   (in_data_reg),
        .nxt    (state_next),
        .result (out_data_next)
    );

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg          <= 1'b0;
            out_valid_reg         <= 1'b0;
            state_reg.cycle_state <= ccs_pkg::ST_IDLE;
            state_reg.wash_count  <= '0;
            state_reg.dry_count   <= '0;
            state_reg.beep_flag   <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // stepped tick always shows up as a result
    `CCS_ASSERT(a_advance_gives_result, advance |=> m_valid)
    // a queued tick is never dropped
    `CCS_ASSERT(a_tick_kept, (in_valid_reg && !advance) |=> in_valid_reg)
    // back-pressure only with a tick queued
    `CCS_ASSERT(a_ready_low_has_tick, !s_ready |-> in_valid_reg)
    // beep only while in the alarm state
    `CCS_ASSERT(a_beep_in_empty, m_valid |-> (!m_data.beep || m_data.mode == ccs_pkg::ST_EMPTY))
    // result follows the committed state
    `CCS_ASSERT(a_mode_matches_state, m_valid |-> (m_data.mode == state_reg.cycle_state))

endmodule

`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           cfg_wr_en = 1'b0;
    logic [ccs_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [ccs_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    ccs_pkg::in_t                   s_data = '0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    ccs_pkg::out_t                  m_data;

    cleaner_cycle_sequencer_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always #10 aclk = ~aclk;

    // shadow of the configuration and of the sequencer state
    logic [ccs_pkg::TICK_W-1:0]  cfg_wash = '0;
    logic [ccs_pkg::TICK_W-1:0]  cfg_dry = '0;
    logic [ccs_pkg::TICK_W-1:0]  cfg_dry_min = '0;
    logic [ccs_pkg::SPEED_W-1:0] cfg_speed = '0;
    logic [ccs_pkg::STATE_W-1:0] cur_state = ccs_pkg::ST_IDLE;
    logic [ccs_pkg::TICK_W-1:0]  wash_cnt = '0;
    logic [ccs_pkg::TICK_W-1:0]  dry_cnt = '0;
    logic                        beep_reg = 1'b0;

    ccs_pkg::out_t pending_results[$];
    int unsigned   gap_pct = 0;
    int unsigned   stall_pct = 0;
    int unsigned   hold_left = 0;
    int unsigned   mismatches = 0;
    int unsigned   ticks_sent = 0;
    int unsigned   results_checked = 0;
    int unsigned   input_stall_cycles = 0;
    int unsigned   finished_cycles = 0;
    logic [7:0]    states_seen = '0;

    function automatic ccs_pkg::out_t step_cycle(input ccs_pkg::in_t t);
        logic [ccs_pkg::STATE_W-1:0] nxt;
        logic [ccs_pkg::SPEED_W-1:0] spd;
        ccs_pkg::out_t               r;
        nxt = cur_state;
        case (cur_state)
            ccs_pkg::ST_IDLE: begin
                wash_cnt = cfg_wash;
                dry_cnt = cfg_dry;
                if (!t.reservoir_ok) nxt = ccs_pkg::ST_EMPTY;
                else if (t.disk_present) nxt = ccs_pkg::ST_READY;
            end
            ccs_pkg::ST_READY: begin
                wash_cnt = cfg_wash;
                dry_cnt = cfg_dry;
                if (!t.disk_present) nxt = ccs_pkg::ST_IDLE;
                else if (t.start_pressed) nxt = ccs_pkg::ST_FILLING;
            end
            ccs_pkg::ST_FILLING: begin
                if (t.tank_full) nxt = ccs_pkg::ST_WASHING;
            end
            ccs_pkg::ST_WASHING: begin
                if (wash_cnt != 0) wash_cnt = wash_cnt - 1'b1;
                if (wash_cnt == 0) nxt = ccs_pkg::ST_UNFILLING;
            end
            ccs_pkg::ST_UNFILLING: begin
                if (!t.tank_drain_sensor) begin
                    if (cfg_dry < cfg_dry_min) begin
                        nxt = ccs_pkg::ST_IDLE;
                    end else begin
                        dry_cnt = cfg_dry;
                        nxt = ccs_pkg::ST_DRYING;
                    end
                end
            end
            ccs_pkg::ST_DRYING: begin
                if (dry_cnt != 0) dry_cnt = dry_cnt - 1'b1;
                if (dry_cnt == 0) nxt = ccs_pkg::ST_FINISHED;
            end
            ccs_pkg::ST_EMPTY: begin
                beep_reg = 1'b1;
                if (t.reservoir_ok) begin
                    nxt = ccs_pkg::ST_IDLE;
                    beep_reg = 1'b0;
                end
            end
            default: begin
                if (!t.disk_present) nxt = ccs_pkg::ST_IDLE;
            end
        endcase
        if (nxt == ccs_pkg::ST_FINISHED && cur_state != ccs_pkg::ST_FINISHED)
            finished_cycles++;
        cur_state = nxt;
        states_seen[nxt] = 1'b1;

        spd = (cfg_speed > ccs_pkg::SPEED_MAX) ? ccs_pkg::SPEED_MAX : cfg_speed;
        r = '0;
        case (nxt)
            ccs_pkg::ST_IDLE, ccs_pkg::ST_READY, ccs_pkg::ST_UNFILLING: r.valve_open = 1'b1;
            ccs_pkg::ST_FILLING: r.pump_on = 1'b1;
            ccs_pkg::ST_WASHING: begin
                r.motor_en = 1'b1;
                r.motor_speed = spd;
                r.ultrasound_on = 1'b1;
            end
            ccs_pkg::ST_DRYING: begin
                r.motor_en = 1'b1;
                r.motor_speed = spd;
                r.fan_on = 1'b1;
            end
            ccs_pkg::ST_EMPTY: begin
                r.motor_en = 1'b1;
                r.fan_on = 1'b1;
                r.valve_open = 1'b1;
            end
            default: begin
                r.motor_en = 1'b1;
                r.fan_on = 1'b1;
            end
        endcase
        r.mode = nxt;
        r.beep = beep_reg;
        r.wash_left = wash_cnt;
        r.dry_left = dry_cnt;
        return r;
    endfunction

    function automatic ccs_pkg::in_t sensors(input logic start, input logic disk,
                                             input logic full, input logic res_ok,
                                             input logic drain);
        ccs_pkg::in_t t;
        t.start_pressed = start;
        t.disk_present = disk;
        t.tank_full = full;
        t.reservoir_ok = res_ok;
        t.tank_drain_sensor = drain;
        return t;
    endfunction

    // mostly plausible sensor readings, with some pure noise
    function automatic ccs_pkg::in_t random_tick();
        ccs_pkg::in_t t;
        if ($urandom_range(0, 4) == 0) begin
            t = ccs_pkg::in_t'(5'($urandom_range(0, 31)));
        end else begin
            t.start_pressed = ($urandom_range(0, 99) < 50);
            t.disk_present = ($urandom_range(0, 99) < 90);
            t.tank_full = ($urandom_range(0, 99) < 50);
            t.reservoir_ok = ($urandom_range(0, 99) < 95);
            t.tank_drain_sensor = ($urandom_range(0, 99) < 50);
        end
        return t;
    endfunction

    // random tick nudged toward the idle state
    function automatic ccs_pkg::in_t homeward_tick();
        ccs_pkg::in_t t;
        t = random_tick();
        case (cur_state)
            ccs_pkg::ST_READY, ccs_pkg::ST_FINISHED: t.disk_present = 1'b0;
            ccs_pkg::ST_FILLING: t.tank_full = 1'b1;
            ccs_pkg::ST_UNFILLING: t.tank_drain_sensor = 1'b0;
            ccs_pkg::ST_EMPTY: t.reservoir_ok = 1'b1;
            default: ;
        endcase
        return t;
    endfunction

    task automatic send_tick(input ccs_pkg::in_t t);
        @(negedge aclk);
        while ($urandom_range(0, 99) < gap_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= t;
        forever begin
            @(posedge aclk);
            if (s_ready) break;
            input_stall_cycles++;
        end
        pending_results.push_back(step_cycle(t));
        ticks_sent++;
    endtask

    task automatic write_reg(input logic [ccs_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ccs_pkg::CFG_DATA_W-1:0] value);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            ccs_pkg::REG_WASH_TICKS: cfg_wash = value;
            ccs_pkg::REG_DRY_TICKS: cfg_dry = value;
            ccs_pkg::REG_DRY_MIN_TICKS: cfg_dry_min = value;
            default: cfg_speed = value[ccs_pkg::SPEED_W-1:0];
        endcase
    endtask

    task automatic configure(input logic [ccs_pkg::CFG_DATA_W-1:0] wash,
                             input logic [ccs_pkg::CFG_DATA_W-1:0] dry,
                             input logic [ccs_pkg::CFG_DATA_W-1:0] dry_min,
                             input logic [ccs_pkg::CFG_DATA_W-1:0] speed);
        write_reg(ccs_pkg::REG_WASH_TICKS, wash);
        write_reg(ccs_pkg::REG_DRY_TICKS, dry);
        write_reg(ccs_pkg::REG_DRY_MIN_TICKS, dry_min);
        write_reg(ccs_pkg::REG_SPEED_PERCENT, speed);
    endtask

    task automatic settle_idle();
        while (cur_state != ccs_pkg::ST_IDLE) send_tick(homeward_tick());
    endtask

    task automatic test_alarm_path();
        send_tick(sensors(0, 0, 0, 0, 0));
        send_tick(sensors(0, 0, 0, 0, 1));
        send_tick(sensors(1, 1, 1, 1, 1));
    endtask

    // zero wash count saturates, dry count of one decrements, speed above range clips
    task automatic test_full_cycle();
        configure(16'd0, 16'd1, 16'd0, 16'd127);
        send_tick(sensors(0, 1, 0, 1, 1));
        send_tick(sensors(0, 1, 0, 1, 1));
        send_tick(sensors(1, 0, 0, 1, 1));
        send_tick(sensors(0, 1, 0, 1, 1));
        send_tick(sensors(1, 1, 0, 1, 1));
        send_tick(sensors(0, 1, 0, 1, 1));
        send_tick(sensors(0, 1, 1, 1, 1));
        send_tick(sensors(0, 1, 1, 1, 1));
        send_tick(sensors(0, 1, 0, 1, 1));
        send_tick(sensors(0, 1, 0, 1, 0));
        send_tick(sensors(0, 1, 0, 1, 0));
        send_tick(sensors(0, 1, 0, 1, 0));
        send_tick(sensors(0, 0, 0, 1, 0));
    endtask

    task automatic test_dry_skip_and_limits();
        configure(16'hFFFF, 16'hFFFE, 16'hFFFF, 16'd100);
        send_tick(sensors(0, 1, 0, 1, 1));
        send_tick(sensors(0, 0, 0, 1, 1));
        write_reg(ccs_pkg::REG_WASH_TICKS, 16'd0);
        send_tick(sensors(1, 1, 0, 1, 1));
        send_tick(sensors(1, 1, 0, 1, 1));
        send_tick(sensors(0, 1, 1, 1, 1));
        send_tick(sensors(0, 1, 1, 1, 1));
        send_tick(sensors(0, 1, 1, 1, 0));
    endtask

    task automatic random_config();
        logic [ccs_pkg::CFG_DATA_W-1:0] wash;
        logic [ccs_pkg::CFG_DATA_W-1:0] dry;
        logic [ccs_pkg::CFG_DATA_W-1:0] dry_min;
        logic [ccs_pkg::CFG_DATA_W-1:0] speed;
        wash = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 6));
        dry = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 6));
        case ($urandom_range(0, 3))
            0: dry_min = 16'd0;
            1: dry_min = 16'hFFFF;
            default: dry_min = 16'($urandom_range(0, 7));
        endcase
        speed = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                            : 16'($urandom_range(0, 127));
        configure(wash, dry, dry_min, speed);
    endtask

    task automatic test_random_traffic(input int unsigned gap, input int unsigned stall,
                                       input int n);
        gap_pct = gap;
        stall_pct = stall;
        for (int i = 0; i < n; i++) begin
            if (i % 60 == 0) begin
                settle_idle();
                random_config();
            end
            send_tick(random_tick());
        end
    endtask

    // long hold on the result side while ticks keep coming
    task automatic test_output_backpressure();
        gap_pct = 0;
        stall_pct = 0;
        settle_idle();
        configure(16'd3, 16'd2, 16'd1, 16'd55);
        hold_left = 300;
        for (int i = 0; i < 40; i++) send_tick(random_tick());
    endtask

    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin : check_results
        ccs_pkg::out_t want;
        ccs_pkg::out_t got;
        if (aresetn && m_valid && m_ready) begin
            got = m_data;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transfer: mode %0d wash %0d dry %0d",
                             got.mode, got.wash_left, got.dry_left);
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if ((got.mode !== want.mode) || (got.motor_en !== want.motor_en) ||
                    (got.motor_speed !== want.motor_speed) ||
                    (got.pump_on !== want.pump_on) || (got.fan_on !== want.fan_on) ||
                    (got.valve_open !== want.valve_open) ||
                    (got.ultrasound_on !== want.ultrasound_on) ||
                    (got.beep !== want.beep) || (got.wash_left !== want.wash_left) ||
                    (got.dry_left !== want.dry_left)) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result %0d exp: mode %0d mot %b spd %0d pump %b fan %b",
                                 results_checked, want.mode, want.motor_en, want.motor_speed,
                                 want.pump_on, want.fan_on);
                        $display("  valve %b us %b beep %b wash %0d dry %0d",
                                 want.valve_open, want.ultrasound_on, want.beep,
                                 want.wash_left, want.dry_left);
                        $display("result %0d got: mode %0d mot %b spd %0d pump %b fan %b",
                                 results_checked, got.mode, got.motor_en, got.motor_speed,
                                 got.pump_on, got.fan_on);
                        $display("  valve %b us %b beep %b wash %0d dry %0d",
                                 got.valve_open, got.ultrasound_on, got.beep,
                                 got.wash_left, got.dry_left);
                    end
                end
            end
        end
    end

    initial begin
        #4000000;
        $display("cleaner_cycle_sequencer_unit regression: fail");
        $finish;
    end

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_alarm_path();
        test_full_cycle();
        test_dry_skip_and_limits();
        test_random_traffic(0, 0, 250);
        test_random_traffic(85, 0, 250);
        test_random_traffic(0, 85, 250);
        test_random_traffic(9, 9, 250);
        test_output_backpressure();

        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (pending_results.size() != 0) mismatches++;

        $display("%0d ticks, %0d results checked, states seen %b, %0d runs to finished",
                 ticks_sent, results_checked, states_seen, finished_cycles);
        $display("%0d cycles with the input stalled, %0d mismatches",
                 input_stall_cycles, mismatches);
        if (mismatches == 0) begin
            $display("cleaner_cycle_sequencer_unit regression: pass");
        end else begin
            $display("cleaner_cycle_sequencer_unit regression: fail");
        end
        $finish;
    end

endmodule
